[design/sckd_pkg.sv]
// Shared types, scancode constants and key lookup tables for the set-1 keyboard decoder.
// Depends on nothing; the front, queue, back and top modules import it.
package sckd_pkg;

    localparam int RING_DEPTH_DEF = 32;
    localparam int KEY_W          = 10;
    localparam int COUNT_W        = 5;

    // Scancode bytes with a fixed meaning.
    localparam logic [7:0] SC_PREFIX     = 8'hE0;
    localparam logic [7:0] SC_CTRL_MAKE  = 8'h1D;
    localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
    localparam logic [7:0] SC_LSHIFT_MK  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MK  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [7:0] SC_CAPS_MAKE  = 8'h3A;

    // Special key codes.
    localparam logic [KEY_W-1:0] K_NONE  = 10'h000;
    localparam logic [KEY_W-1:0] K_ESC   = 10'h100;
    localparam logic [KEY_W-1:0] K_BKSP  = 10'h101;
    localparam logic [KEY_W-1:0] K_TAB   = 10'h102;
    localparam logic [KEY_W-1:0] K_ENTER = 10'h103;
    localparam logic [KEY_W-1:0] K_F1    = 10'h104;
    localparam logic [KEY_W-1:0] K_F2    = 10'h105;
    localparam logic [KEY_W-1:0] K_F3    = 10'h106;
    localparam logic [KEY_W-1:0] K_F4    = 10'h107;
    localparam logic [KEY_W-1:0] K_F10   = 10'h108;
    localparam logic [KEY_W-1:0] K_HOME  = 10'h109;
    localparam logic [KEY_W-1:0] K_UP    = 10'h10A;
    localparam logic [KEY_W-1:0] K_PGUP  = 10'h10B;
    localparam logic [KEY_W-1:0] K_LEFT  = 10'h10C;
    localparam logic [KEY_W-1:0] K_RIGHT = 10'h10D;
    localparam logic [KEY_W-1:0] K_END   = 10'h10E;
    localparam logic [KEY_W-1:0] K_DOWN  = 10'h10F;
    localparam logic [KEY_W-1:0] K_PGDN  = 10'h110;
    localparam logic [KEY_W-1:0] K_INS   = 10'h111;
    localparam logic [KEY_W-1:0] K_DEL   = 10'h112;

    localparam logic [KEY_W-1:0] CTRL_FLAG  = 10'h200;
    localparam logic [KEY_W-1:0] CASE_DELTA = 10'h020;
    localparam logic [KEY_W-1:0] CHAR_LO_A  = 10'h061;
    localparam logic [KEY_W-1:0] CHAR_LO_Z  = 10'h07A;

    // One classified operation handed from the front end to the back end.
    typedef struct packed {
        logic             poll;
        logic             push;
        logic [KEY_W-1:0] key;
    } t_op;

    function automatic logic [KEY_W-1:0] map_qwerty(input logic [6:0] code);
        logic [KEY_W-1:0] k;
        case (code)
            7'h01: k = K_ESC;    7'h02: k = 10'h031;  7'h03: k = 10'h032;
            7'h04: k = 10'h033;  7'h05: k = 10'h034;  7'h06: k = 10'h035;
            7'h07: k = 10'h036;  7'h08: k = 10'h037;  7'h09: k = 10'h038;
            7'h0A: k = 10'h039;  7'h0B: k = 10'h030;  7'h0C: k = 10'h02D;
            7'h0D: k = 10'h03D;  7'h0E: k = K_BKSP;   7'h0F: k = K_TAB;
            7'h10: k = 10'h071;  7'h11: k = 10'h077;  7'h12: k = 10'h065;
            7'h13: k = 10'h072;  7'h14: k = 10'h074;  7'h15: k = 10'h079;
            7'h16: k = 10'h075;  7'h17: k = 10'h069;  7'h18: k = 10'h06F;
            7'h19: k = 10'h070;  7'h1A: k = 10'h05B;  7'h1B: k = 10'h05D;
            7'h1C: k = K_ENTER;  7'h1E: k = 10'h061;  7'h1F: k = 10'h073;
            7'h20: k = 10'h064;  7'h21: k = 10'h066;  7'h22: k = 10'h067;
            7'h23: k = 10'h068;  7'h24: k = 10'h06A;  7'h25: k = 10'h06B;
            7'h26: k = 10'h06C;  7'h27: k = 10'h03B;  7'h28: k = 10'h027;
            7'h29: k = 10'h060;  7'h2B: k = 10'h05C;  7'h2C: k = 10'h07A;
            7'h2D: k = 10'h078;  7'h2E: k = 10'h063;  7'h2F: k = 10'h076;
            7'h30: k = 10'h062;  7'h31: k = 10'h06E;  7'h32: k = 10'h06D;
            7'h33: k = 10'h02C;  7'h34: k = 10'h02E;  7'h35: k = 10'h02F;
            7'h39: k = 10'h020;  7'h3B: k = K_F1;     7'h3C: k = K_F2;
            7'h3D: k = K_F3;     7'h3E: k = K_F4;     7'h44: k = K_F10;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    // AZERTY differs from QWERTY on a handful of positions only.
    function automatic logic [KEY_W-1:0] map_azerty(input logic [6:0] code);
        logic [KEY_W-1:0] k;
        case (code)
            7'h10: k = 10'h061;
            7'h11: k = 10'h07A;
            7'h1E: k = 10'h071;
            7'h27: k = 10'h06D;
            7'h2C: k = 10'h077;
            7'h32: k = 10'h02C;
            7'h33: k = 10'h03B;
            default: k = map_qwerty(code);
        endcase
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] map_extended(input logic [6:0] code);
        logic [KEY_W-1:0] k;
        case (code)
            7'h47: k = K_HOME;
            7'h48: k = K_UP;
            7'h49: k = K_PGUP;
            7'h4B: k = K_LEFT;
            7'h4D: k = K_RIGHT;
            7'h4F: k = K_END;
            7'h50: k = K_DOWN;
            7'h51: k = K_PGDN;
            7'h52: k = K_INS;
            7'h53: k = K_DEL;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] shifted_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] s;
        case (k)
            10'h031: s = 10'h021;  10'h032: s = 10'h040;  10'h033: s = 10'h023;
            10'h034: s = 10'h024;  10'h035: s = 10'h025;  10'h036: s = 10'h05E;
            10'h037: s = 10'h026;  10'h038: s = 10'h02A;  10'h039: s = 10'h028;
            10'h030: s = 10'h029;  10'h02D: s = 10'h05F;  10'h03D: s = 10'h02B;
            10'h05B: s = 10'h07B;  10'h05D: s = 10'h07D;  10'h03B: s = 10'h03A;
            10'h027: s = 10'h022;  10'h060: s = 10'h07E;  10'h05C: s = 10'h07C;
            10'h02C: s = 10'h03C;  10'h02E: s = 10'h03E;  10'h02F: s = 10'h03F;
            default: s = k;
        endcase
        return s;
    endfunction

endpackage

[design/sckd_front.sv]
// Front end: accepts input words, tracks modifier and prefix state, and classifies each
// word into a poll, a key push or a no-op operation. Depends on sckd_pkg.
module sckd_front
    import sckd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_layout_select,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_cmd,
    input  logic [7:0] i_scan_byte,
    output logic       o_op_valid,
    input  logic       i_op_ready,
    output t_op        o_op
);

    logic r_shift_held;
    logic r_caps_on;
    logic r_ctrl_held;
    logic r_prefix_pending;
    logic n_shift_held;
    logic n_caps_on;
    logic n_ctrl_held;
    logic n_prefix_pending;
    logic             accept;
    logic [KEY_W-1:0] base_key;
    logic [KEY_W-1:0] key;
    t_op              op;

    assign o_in_ready = i_op_ready;
    assign o_op_valid = i_in_valid;
    assign accept     = i_in_valid && i_op_ready;
    assign o_op       = op;

    assign base_key = i_layout_select ? map_azerty(i_scan_byte[6:0])
                                      : map_qwerty(i_scan_byte[6:0]);

    always_comb begin
        n_shift_held     = r_shift_held;
        n_caps_on        = r_caps_on;
        n_ctrl_held      = r_ctrl_held;
        n_prefix_pending = r_prefix_pending;
        key              = K_NONE;
        op.poll          = i_cmd;
        op.push          = 1'b0;
        if (!i_cmd) begin
            if (i_scan_byte == SC_PREFIX) begin
                n_prefix_pending = 1'b1;
            end else if (i_scan_byte == SC_CTRL_MAKE) begin
                n_ctrl_held = 1'b1;
            end else if (i_scan_byte == SC_CTRL_BRK) begin
                n_ctrl_held = 1'b0;
            end else if (i_scan_byte == SC_LSHIFT_MK || i_scan_byte == SC_RSHIFT_MK) begin
                n_shift_held = 1'b1;
            end else if (i_scan_byte == SC_LSHIFT_BRK || i_scan_byte == SC_RSHIFT_BRK) begin
                n_shift_held = 1'b0;
            end else if (i_scan_byte == SC_CAPS_MAKE) begin
                n_caps_on = !r_caps_on;
            end else if (i_scan_byte[7]) begin
                n_prefix_pending = 1'b0;
            end else if (r_prefix_pending) begin
                // Extended keys ignore every modifier.
                n_prefix_pending = 1'b0;
                key              = map_extended(i_scan_byte[6:0]);
            end else if (base_key >= CHAR_LO_A && base_key <= CHAR_LO_Z) begin
                if (r_ctrl_held) begin
                    key = CTRL_FLAG | base_key;
                end else if (r_shift_held != r_caps_on) begin
                    key = base_key - CASE_DELTA;
                end else begin
                    key = base_key;
                end
            end else if (r_shift_held) begin
                key = shifted_key(base_key);
            end else begin
                key = base_key;
            end
            op.push = (key != K_NONE);
        end
        op.key = key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_held     <= 1'b0;
            r_caps_on        <= 1'b0;
            r_ctrl_held      <= 1'b0;
            r_prefix_pending <= 1'b0;
        end else if (accept) begin
            r_shift_held     <= n_shift_held;
            r_caps_on        <= n_caps_on;
            r_ctrl_held      <= n_ctrl_held;
            r_prefix_pending <= n_prefix_pending;
        end
    end

endmodule

[design/sckd_queue.sv]
// Two-entry operation queue between the front end and the back end.
// Depends on sckd_pkg for the operation type.
module sckd_queue
    import sckd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_op  i_push_op,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_op  o_pop_op
);

    t_op        r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_op     = r_slot[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_push_op;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[design/sckd_back.sv]
// Back end: key ring memory with read and write indexes, executing pushes and polls,
// and the registered result stage. Depends on sckd_pkg.
module sckd_back
    import sckd_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_op_valid,
    output logic               o_op_ready,
    input  t_op                i_op,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_key_valid,
    output logic [KEY_W-1:0]   o_key_code,
    output logic [COUNT_W-1:0] o_queue_count,
    output logic               o_dropped
);

    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int XW = (IW + 1 > COUNT_W) ? IW + 1 : COUNT_W;
    localparam logic [IW-1:0] LAST_INDEX = IW'(RING_DEPTH - 1);
    localparam logic [XW-1:0] DEPTH_X    = XW'(RING_DEPTH);

    logic [KEY_W-1:0]   r_ring [RING_DEPTH];
    logic [IW-1:0]      r_wr;
    logic [IW-1:0]      r_rd;
    logic [IW-1:0]      n_wr;
    logic [IW-1:0]      n_rd;
    logic               r_out_valid;
    logic               r_key_valid;
    logic [KEY_W-1:0]   r_read_data;
    logic [COUNT_W-1:0] r_count;
    logic               r_dropped;
    logic               n_key_valid;
    logic               n_dropped;
    logic               do_write;
    logic               take;
    logic [IW-1:0]      wr_adv;
    logic [IW-1:0]      rd_adv;
    logic [XW-1:0]      count_x;

    assign o_op_ready  = !r_out_valid || i_out_ready;
    assign take        = i_op_valid && o_op_ready;
    assign wr_adv      = (r_wr == LAST_INDEX) ? '0 : r_wr + 1'b1;
    assign rd_adv      = (r_rd == LAST_INDEX) ? '0 : r_rd + 1'b1;

    always_comb begin
        n_wr        = r_wr;
        n_rd        = r_rd;
        n_key_valid = 1'b0;
        n_dropped   = 1'b0;
        do_write    = 1'b0;
        if (i_op.poll) begin
            if (r_rd != r_wr) begin
                n_key_valid = 1'b1;
                n_rd        = rd_adv;
            end
        end else if (i_op.push) begin
            // One slot stays free so that equal indexes always mean empty.
            if (wr_adv == r_rd) begin
                n_dropped = 1'b1;
            end else begin
                do_write = 1'b1;
                n_wr     = wr_adv;
            end
        end
        if (n_wr >= n_rd) begin
            count_x = XW'(n_wr) - XW'(n_rd);
        end else begin
            count_x = XW'(n_wr) + DEPTH_X - XW'(n_rd);
        end
    end

    // A poll only reads an entry written in an earlier cycle, so no bypass is needed.
    always_ff @(posedge i_clk) begin
        if (take && do_write) begin
            r_ring[r_wr] <= i_op.key;
        end
        if (take) begin
            r_read_data <= r_ring[r_rd];
            r_count     <= count_x[COUNT_W-1:0];
            r_dropped   <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_out_valid <= 1'b0;
            r_key_valid <= 1'b0;
        end else begin
            if (take) begin
                r_wr        <= n_wr;
                r_rd        <= n_rd;
                r_key_valid <= n_key_valid;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_key_valid   = r_key_valid;
    assign o_key_code    = r_key_valid ? r_read_data : K_NONE;
    assign o_queue_count = r_count;
    assign o_dropped     = r_dropped;

endmodule

[design/scancode_to_key_decoder_fifo_top.sv]
// Set-1 scancode decoder with a key ring: front end, two-entry queue, back end.
// A result word passes through the two-entry queue and then the registered result stage
// of the back end before its result handshake.
// Throughput: one word per cycle unless i_out_ready stalls; one ring access per word.
// Reset (synchronous, active low) clears modifiers, prefix, ring indexes and handshakes;
// the ring storage is not cleared and needs no clearing pass. Layout resets to QWERTY.
// Depends on sckd_pkg, sckd_front, sckd_queue and sckd_back.
module scancode_to_key_decoder_fifo_top
    import sckd_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_layout_select,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [7:0]         i_scan_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_key_valid,
    output logic [KEY_W-1:0]   o_key_code,
    output logic [COUNT_W-1:0] o_queue_count,
    output logic               o_dropped
);

    logic r_layout_select;
    logic front_valid;
    logic front_ready;
    t_op  front_op;
    logic back_valid;
    logic back_ready;
    t_op  back_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout_select <= 1'b0;
        end else if (i_cfg_valid) begin
            r_layout_select <= i_cfg_layout_select;
        end
    end

    sckd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_layout_select (r_layout_select),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_scan_byte     (i_scan_byte),
        .o_op_valid      (front_valid),
        .i_op_ready      (front_ready),
        .o_op            (front_op)
    );

    sckd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_op    (front_op),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_op     (back_op)
    );

    sckd_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op_valid    (back_valid),
        .o_op_ready    (back_ready),
        .i_op          (back_op),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_key_valid   (o_key_valid),
        .o_key_code    (o_key_code),
        .o_queue_count (o_queue_count),
        .o_dropped     (o_dropped)
    );

endmodule

[verif/key_decoder_checker.sv]
// Scoreboard for the set-1 scancode decoder: a small package of command and layout codes,
// and a checker that watches the config, input and result channels and predicts every word.
// Depends on sckd_pkg for key codes and scancode constants.
package key_tb_pkg;

    typedef enum logic {
        CMD_SCAN = 1'b0,
        CMD_POLL = 1'b1
    } cmd_e;

    typedef enum logic {
        LAYOUT_QWERTY = 1'b0,
        LAYOUT_AZERTY = 1'b1
    } layout_e;

endpackage

module key_decoder_checker
    import sckd_pkg::*;
    import key_tb_pkg::*;
#(
    parameter int DEPTH = RING_DEPTH_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_layout_select,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_cmd,
    input  logic [7:0]         i_scan_byte,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_key_valid,
    input  logic [KEY_W-1:0]   i_key_code,
    input  logic [COUNT_W-1:0] i_queue_count,
    input  logic               i_dropped,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_keys_seen,
    output int                 o_drops_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               key_valid;
        logic [KEY_W-1:0]   key_code;
        logic [COUNT_W-1:0] queue_count;
        logic               dropped;
    } key_result_t;

    key_result_t expected_keys [$];

    // Shadow of the decoder state.
    logic [KEY_W-1:0] key_ring [DEPTH];
    int               wr_ptr;
    int               rd_ptr;
    logic             shift_down;
    logic             caps_lock;
    logic             ctrl_down;
    logic             ext_prefix;
    logic             layout_sel;

    int          fail_count;
    int          keys_seen;
    int          drops_seen;
    key_result_t want;
    key_result_t got;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_keys.size();
    assign o_keys_seen  = keys_seen;
    assign o_drops_seen = drops_seen;

    function automatic logic [KEY_W-1:0] asc(input logic [7:0] ch);
        return {2'b00, ch};
    endfunction

    function automatic logic [KEY_W-1:0] layout_key(input logic [6:0] c, input logic az);
        logic [KEY_W-1:0] k;
        k = K_NONE;
        // The digit row runs 1..9 on codes 0x02..0x0A.
        if (c >= 7'h02 && c <= 7'h0A) begin
            k = asc(8'h2F + {1'b0, c});
        end else begin
            case (c)
                7'h01: k = K_ESC;
                7'h0B: k = asc("0");
                7'h0C: k = asc("-");
                7'h0D: k = asc("=");
                7'h0E: k = K_BKSP;
                7'h0F: k = K_TAB;
                7'h10: k = asc(az ? "a" : "q");
                7'h11: k = asc(az ? "z" : "w");
                7'h12: k = asc("e");
                7'h13: k = asc("r");
                7'h14: k = asc("t");
                7'h15: k = asc("y");
                7'h16: k = asc("u");
                7'h17: k = asc("i");
                7'h18: k = asc("o");
                7'h19: k = asc("p");
                7'h1A: k = asc("[");
                7'h1B: k = asc("]");
                7'h1C: k = K_ENTER;
                7'h1E: k = asc(az ? "q" : "a");
                7'h1F: k = asc("s");
                7'h20: k = asc("d");
                7'h21: k = asc("f");
                7'h22: k = asc("g");
                7'h23: k = asc("h");
                7'h24: k = asc("j");
                7'h25: k = asc("k");
                7'h26: k = asc("l");
                7'h27: k = asc(az ? "m" : ";");
                7'h28: k = asc("'");
                7'h29: k = asc(8'h60);  // backtick
                7'h2B: k = asc("\\");
                7'h2C: k = asc(az ? "w" : "z");
                7'h2D: k = asc("x");
                7'h2E: k = asc("c");
                7'h2F: k = asc("v");
                7'h30: k = asc("b");
                7'h31: k = asc("n");
                7'h32: k = asc(az ? "," : "m");
                7'h33: k = asc(az ? ";" : ",");
                7'h34: k = asc(".");
                7'h35: k = asc("/");
                7'h39: k = asc(" ");
                7'h3B: k = K_F1;
                7'h3C: k = K_F2;
                7'h3D: k = K_F3;
                7'h3E: k = K_F4;
                7'h44: k = K_F10;
                default: k = K_NONE;
            endcase
        end
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] nav_key(input logic [6:0] c);
        logic [KEY_W-1:0] k;
        case (c)
            7'h47: k = K_HOME;
            7'h48: k = K_UP;
            7'h49: k = K_PGUP;
            7'h4B: k = K_LEFT;
            7'h4D: k = K_RIGHT;
            7'h4F: k = K_END;
            7'h50: k = K_DOWN;
            7'h51: k = K_PGDN;
            7'h52: k = K_INS;
            7'h53: k = K_DEL;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] shift_symbol(input logic [KEY_W-1:0] k);
        logic [7:0] ch;
        if (k[KEY_W-1:8] != '0) return k;
        case (k[7:0])
            "1": ch = "!";
            "2": ch = "@";
            "3": ch = "#";
            "4": ch = "$";
            "5": ch = "%";
            "6": ch = "^";
            "7": ch = "&";
            "8": ch = "*";
            "9": ch = "(";
            "0": ch = ")";
            "-": ch = "_";
            "=": ch = "+";
            "[": ch = "{";
            "]": ch = "}";
            ";": ch = ":";
            "'": ch = "\"";
            8'h60: ch = "~";
            "\\": ch = "|";
            ",": ch = "<";
            ".": ch = ">";
            "/": ch = "?";
            default: ch = k[7:0];
        endcase
        return {2'b00, ch};
    endfunction

    // Applies one scancode byte to the shadow state; lost is set when the ring was full.
    task automatic decode_scan(input logic [7:0] b, output logic lost);
        logic [KEY_W-1:0] k;
        lost = 1'b0;
        k = K_NONE;
        case (b)
            SC_PREFIX:                    ext_prefix = 1'b1;
            SC_CTRL_MAKE:                 ctrl_down = 1'b1;
            SC_CTRL_BRK:                  ctrl_down = 1'b0;
            SC_LSHIFT_MK, SC_RSHIFT_MK:   shift_down = 1'b1;
            SC_LSHIFT_BRK, SC_RSHIFT_BRK: shift_down = 1'b0;
            SC_CAPS_MAKE:                 caps_lock = ~caps_lock;
            default: begin
                if (b[7]) begin
                    ext_prefix = 1'b0;
                end else if (ext_prefix) begin
                    ext_prefix = 1'b0;
                    k = nav_key(b[6:0]);
                end else begin
                    k = layout_key(b[6:0], layout_sel);
                    if (k >= CHAR_LO_A && k <= CHAR_LO_Z) begin
                        if (ctrl_down)
                            k = CTRL_FLAG | k;
                        else if (shift_down != caps_lock)
                            k = k - CASE_DELTA;
                    end else if (shift_down) begin
                        k = shift_symbol(k);
                    end
                end
            end
        endcase
        if (k != K_NONE) begin
            if ((wr_ptr + 1) % DEPTH == rd_ptr) begin
                lost = 1'b1;
            end else begin
                key_ring[wr_ptr] = k;
                wr_ptr = (wr_ptr + 1) % DEPTH;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_ptr     = 0;
            rd_ptr     = 0;
            shift_down = 1'b0;
            caps_lock  = 1'b0;
            ctrl_down  = 1'b0;
            ext_prefix = 1'b0;
            layout_sel = LAYOUT_QWERTY;
            fail_count = 0;
            keys_seen  = 0;
            drops_seen = 0;
            expected_keys.delete();
        end else begin
            // Results are compared before this edge's input word is predicted.
            if (i_out_valid && i_out_ready) begin
                got = '{i_key_valid, i_key_code, i_queue_count, i_dropped};
                if (i_key_valid === 1'b1) keys_seen++;
                if (i_dropped === 1'b1) drops_seen++;
                if (expected_keys.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result word with nothing expected: valid=%0b code=%h",
                                 $time, got.key_valid, got.key_code);
                    fail_count++;
                end else begin
                    want = expected_keys.pop_front();
                    if (got.key_valid !== want.key_valid || got.key_code !== want.key_code ||
                        got.queue_count !== want.queue_count || got.dropped !== want.dropped) begin
                        if (fail_count < 10) begin
                            $write("%0t: mismatch, expected valid=%0b code=%h count=%0d ",
                                   $time, want.key_valid, want.key_code, want.queue_count);
                            $display("dropped=%0b, got valid=%0b code=%h count=%0d dropped=%0b",
                                     want.dropped, got.key_valid, got.key_code,
                                     got.queue_count, got.dropped);
                        end
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                layout_sel = i_cfg_layout_select;
            if (i_in_valid && i_in_ready) begin
                want = '0;
                if (i_cmd == CMD_POLL) begin
                    if (rd_ptr != wr_ptr) begin
                        want.key_valid = 1'b1;
                        want.key_code  = key_ring[rd_ptr];
                        rd_ptr         = (rd_ptr + 1) % DEPTH;
                    end
                end else begin
                    decode_scan(i_scan_byte, want.dropped);
                end
                want.queue_count = COUNT_W'((wr_ptr - rd_ptr + DEPTH) % DEPTH);
                expected_keys.push_back(want);
            end
        end
    end

endmodule

[verif/testbench.sv]
// Top of the decoder testbench: clock, reset, stimulus for the config and input channels,
// a stalling result receiver and the verdict. Depends on sckd_pkg, key_tb_pkg,
// key_decoder_checker and scancode_to_key_decoder_fifo_top.
module testbench;
    import sckd_pkg::*;
    import key_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 300000;

    localparam logic [7:0] MODIFIER_BYTES [7] = '{
        SC_CTRL_MAKE, SC_CTRL_BRK, SC_LSHIFT_MK, SC_RSHIFT_MK,
        SC_LSHIFT_BRK, SC_RSHIFT_BRK, SC_CAPS_MAKE
    };
    localparam logic [7:0] NAV_BYTES [10] = '{
        8'h47, 8'h48, 8'h49, 8'h4B, 8'h4D, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53
    };

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_TIGHT
    } rx_mode_e;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic               cfg_layout  = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic               in_cmd      = 1'b0;
    logic [7:0]         in_byte     = 8'h00;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic               key_valid;
    logic [KEY_W-1:0]   key_code;
    logic [COUNT_W-1:0] queue_count;
    logic               dropped;

    int          fail_count;
    int          pending;
    int          keys_seen;
    int          drops_seen;
    int          words_sent   = 0;
    int          polls_sent   = 0;
    int          burst_left   = 0;
    bit          hold_request = 1'b0;
    int unsigned cycle_count  = 0;

    always #1 clk = ~clk;

    scancode_to_key_decoder_fifo_top u_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_layout_select (cfg_layout),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_cmd               (in_cmd),
        .i_scan_byte         (in_byte),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_key_valid         (key_valid),
        .o_key_code          (key_code),
        .o_queue_count       (queue_count),
        .o_dropped           (dropped)
    );

    key_decoder_checker u_check (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_ready         (cfg_ready),
        .i_cfg_layout_select (cfg_layout),
        .i_in_valid          (in_valid),
        .i_in_ready          (in_ready),
        .i_cmd               (in_cmd),
        .i_scan_byte         (in_byte),
        .i_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .i_key_valid         (key_valid),
        .i_key_code          (key_code),
        .i_queue_count       (queue_count),
        .i_dropped           (dropped),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_keys_seen         (keys_seen),
        .o_drops_seen        (drops_seen)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("scancode_to_key_decoder_fifo_top verification failed");
            $finish;
        end
    end

    // Result receiver: random stall modes, plus a long hold-off when one is requested.
    initial begin
        rx_mode_e mode;
        int       mode_left;
        int       hold_left;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 200;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_e'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 100);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:  out_ready <= 1'b1;
                    RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
                    default:  out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offers one word and returns once it is accepted; valid stays high into the next
    // word of a burst and drops only for a gap.
    task automatic send_word(input cmd_e cmd, input logic [7:0] b);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(8, 20)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_byte  <= b;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        if (cmd == CMD_POLL) polls_sent++;
    endtask

    task automatic wait_idle();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        // Let the pipeline settle before touching the register.
        repeat (4) @(posedge clk);
    endtask

    task automatic write_layout(input layout_e lay);
        wait_idle();
        cfg_valid  <= 1'b1;
        cfg_layout <= lay;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One random keystroke: mostly well-formed make/break sequences, some broken ones.
    task automatic send_keystroke(input int poll_pct);
        int         pick;
        logic [7:0] b;
        if ($urandom_range(0, 99) < poll_pct) begin
            send_word(CMD_POLL, 8'($urandom_range(0, 255)));
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            b = 8'($urandom_range(8'h01, 8'h44));
            send_word(CMD_SCAN, b);
            if ($urandom_range(0, 3) != 0) send_word(CMD_SCAN, b | 8'h80);
        end else if (pick < 70) begin
            send_word(CMD_SCAN, MODIFIER_BYTES[$urandom_range(0, 6)]);
        end else if (pick < 88) begin
            b = ($urandom_range(0, 4) != 0) ? NAV_BYTES[$urandom_range(0, 9)]
                                            : 8'($urandom_range(0, 127));
            send_word(CMD_SCAN, SC_PREFIX);
            send_word(CMD_SCAN, b);
            if ($urandom_range(0, 1) != 0) begin
                send_word(CMD_SCAN, SC_PREFIX);
                send_word(CMD_SCAN, b | 8'h80);
            end
        end else if (pick < 95) begin
            // A lone prefix, or a prefix followed by a modifier.
            send_word(CMD_SCAN, SC_PREFIX);
            if ($urandom_range(0, 1) != 0)
                send_word(CMD_SCAN, MODIFIER_BYTES[$urandom_range(0, 6)]);
        end else begin
            send_word(CMD_SCAN, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_phase(input layout_e lay, input int words, input int poll_pct,
                                input bit long_hold);
        int stop_at;
        write_layout(lay);
        if (long_hold) hold_request = 1'b1;
        stop_at = words_sent + words;
        while (words_sent < stop_at) send_keystroke(poll_pct);
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_layout(LAYOUT_QWERTY);
        // Empty poll, shifted digit and letter, caps, ctrl letter, extended keys,
        // extended break, modifier inside a prefix, unmapped codes and breaks.
        send_word(CMD_POLL, 8'hFF);
        send_word(CMD_SCAN, 8'h1E);
        send_word(CMD_SCAN, SC_LSHIFT_MK);
        send_word(CMD_SCAN, 8'h02);
        send_word(CMD_SCAN, 8'h1E);
        send_word(CMD_SCAN, SC_RSHIFT_BRK);
        send_word(CMD_SCAN, SC_CAPS_MAKE);
        send_word(CMD_SCAN, 8'h10);
        send_word(CMD_SCAN, SC_CTRL_MAKE);
        send_word(CMD_SCAN, 8'h2C);
        send_word(CMD_SCAN, SC_CTRL_BRK);
        send_word(CMD_SCAN, SC_CAPS_MAKE);
        send_word(CMD_SCAN, SC_PREFIX);
        send_word(CMD_SCAN, 8'h48);
        send_word(CMD_SCAN, SC_PREFIX);
        send_word(CMD_SCAN, 8'hC8);
        send_word(CMD_SCAN, SC_PREFIX);
        send_word(CMD_SCAN, SC_LSHIFT_MK);
        send_word(CMD_SCAN, 8'h53);
        send_word(CMD_SCAN, SC_LSHIFT_BRK);
        send_word(CMD_SCAN, SC_PREFIX);
        send_word(CMD_SCAN, 8'h10);
        send_word(CMD_SCAN, 8'h00);
        send_word(CMD_SCAN, 8'hFF);
        send_word(CMD_SCAN, 8'h44);
        send_word(CMD_POLL, 8'h00);

        // Rare polls fill the ring and force drops; later phases drain it again.
        random_phase(LAYOUT_AZERTY, 200, 5, 1'b1);
        random_phase(LAYOUT_QWERTY, 150, 60, 1'b0);
        random_phase(LAYOUT_AZERTY, 150, 45, 1'b1);
        random_phase(LAYOUT_QWERTY, 100, 35, 1'b0);

        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d words (%0d polls) across both keymap layouts and two long stalls;",
                 words_sent, polls_sent);
        $display("%0d keys came back from the ring and %0d keys were lost to a full ring.",
                 keys_seen, drops_seen);
        if (fail_count == 0)
            $display("scancode_to_key_decoder_fifo_top verification clean");
        else
            $display("scancode_to_key_decoder_fifo_top verification failed");
        $finish;
    end

endmodule

[files.f]
design/sckd_pkg.sv
design/sckd_front.sv
design/sckd_queue.sv
design/sckd_back.sv
design/scancode_to_key_decoder_fifo_top.sv
verif/key_decoder_checker.sv
verif/testbench.sv
